// ===== src/sjf_pkg.sv =====
// shared types and constants for the shortest-job-first scheduler
// no dependencies; used by every module of the block
package sjf_pkg;

    localparam int MAX_PROCS = 16;

    localparam int BURST_W = 16;
    localparam int ARR_W   = 16;
    localparam int ID_W    = 6;
    localparam int TIME_W  = 23;

    // table index and job count widths
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    // front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // one loaded job as it travels from front to back
    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic [ARR_W-1:0]   arrival;
        logic [IDX_W-1:0]   idx;
        logic               last;
    } job_word_t;

    // back-end status seen at the top level
    typedef struct packed {
        logic loading;
        logic picking;
    } back_stat_t;

endpackage

// ===== src/sjf_nonpreemptive_scheduler.sv =====
// top level of the non-preemptive shortest-job-first scheduler
// depends on sjf_pkg, sjf_front, sjf_queue and sjf_back
//
//  channel  | handshake          | word fields
//  ---------+--------------------+------------------------------------------------
//  input    | push / full        | burst_time, arrival_time, last_entry
//  result   | empty / pop        | job_id, job_burst, job_arrival, start_time,
//           |                    | finish_time, last_result
//
// an input word passes the front without delay into a two-word queue; the back
// moves one word per cycle from a non-empty queue into its job table while loading
// each result of a set of n jobs takes a scan of all n table entries, one entry
// per cycle, then a pick
// while a set is scheduled the queue fills and full holds off input; a stalled
// result holds in the result register and the pick waits; reset clears control
module sjf_nonpreemptive_scheduler (
    input  logic                        clk,
    input  logic                        rst_n,
    // input side
    input  logic                        push,
    output logic                        full,
    input  logic [sjf_pkg::BURST_W-1:0] burst_time,
    input  logic [sjf_pkg::ARR_W-1:0]   arrival_time,
    input  logic                        last_entry,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic [sjf_pkg::ID_W-1:0]    job_id,
    output logic [sjf_pkg::BURST_W-1:0] job_burst,
    output logic [sjf_pkg::ARR_W-1:0]   job_arrival,
    output logic [sjf_pkg::TIME_W-1:0]  start_time,
    output logic [sjf_pkg::TIME_W-1:0]  finish_time,
    output logic                        last_result
);

    // front to queue
    logic               q_push;
    logic               q_full;
    sjf_pkg::job_word_t q_wr_word;
    // queue to back
    logic               q_pop;
    logic               q_empty;
    sjf_pkg::job_word_t q_rd_word;
    // back status
    sjf_pkg::back_stat_t back_stat;

    // numbers each word and flags the end of a set
    sjf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .burst_time   (burst_time),
        .arrival_time (arrival_time),
        .last_entry   (last_entry),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_word       (q_wr_word)
    );

    // decouples the input handshake from the scheduling back end
    sjf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_word (q_wr_word),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_word (q_rd_word),
        .empty   (q_empty)
    );

    // job table, scan and result register
    sjf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_word      (q_rd_word),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .job_id      (job_id),
        .job_burst   (job_burst),
        .job_arrival (job_arrival),
        .start_time  (start_time),
        .finish_time (finish_time),
        .last_result (last_result),
        .stat        (back_stat)
    );

`ifndef SYNTH
    // the back only drains the queue while loading
    a_pop_only_loading : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> back_stat.loading)
        else $error("queue drained outside of loading");

    // a full queue is never empty
    a_queue_count : assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_empty)
        else $error("queue full and empty at once");

    // a pick blocked by a waiting result stays pending
    a_pick_waits : assert property (@(posedge clk) disable iff (!rst_n)
        (back_stat.picking && !empty && !pop) |=> back_stat.picking)
        else $error("pick lost while result stalled");
`endif

endmodule

// ===== src/sjf_front.sv =====
// front end: accepts job words, numbers them and marks the end of a set
// depends on sjf_pkg
module sjf_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [sjf_pkg::BURST_W-1:0] burst_time,
    input  logic [sjf_pkg::ARR_W-1:0]   arrival_time,
    input  logic                       last_entry,
    input  logic                       q_full,
    output logic                       q_push,
    output sjf_pkg::job_word_t         q_word
);

    logic [sjf_pkg::IDX_W-1:0] idx_reg;
    logic [sjf_pkg::IDX_W-1:0] idx_next;
    logic                      set_end;

    assign full    = q_full;
    assign q_push  = push && !q_full;
    // a set ends on the flagged word or on the word that fills the table
    assign set_end = last_entry ||
                     (idx_reg == sjf_pkg::IDX_W'(sjf_pkg::MAX_PROCS - 1));

    assign q_word.burst   = burst_time;
    assign q_word.arrival = arrival_time;
    assign q_word.idx     = idx_reg;
    assign q_word.last    = set_end;

    always_comb
    begin
        idx_next = idx_reg;
        if (q_push)
        begin
            idx_next = set_end ? '0 : idx_reg + sjf_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

// ===== src/sjf_queue.sv =====
// two-entry queue of job words between front and back
// depends on sjf_pkg
module sjf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  sjf_pkg::job_word_t wr_word,
    output logic               full,
    input  logic               rd_en,
    output sjf_pkg::job_word_t rd_word,
    output logic               empty
);

    sjf_pkg::job_word_t         slot_reg [sjf_pkg::QUEUE_DEPTH];
    logic [sjf_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [sjf_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [sjf_pkg::QCNT_W-1:0] cnt_reg;
    logic                       do_wr;
    logic                       do_rd;

    assign full    = (cnt_reg == sjf_pkg::QCNT_W'(sjf_pkg::QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_word = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + sjf_pkg::QPTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + sjf_pkg::QPTR_W'(1);
            end
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + sjf_pkg::QCNT_W'(1);
                2'b01:   cnt_reg <= cnt_reg - sjf_pkg::QCNT_W'(1);
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ===== src/sjf_back.sv =====
// back end: job table, per-pick scan and result register
// depends on sjf_pkg
module sjf_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  sjf_pkg::job_word_t          q_word,
    output logic                        q_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [sjf_pkg::ID_W-1:0]    job_id,
    output logic [sjf_pkg::BURST_W-1:0] job_burst,
    output logic [sjf_pkg::ARR_W-1:0]   job_arrival,
    output logic [sjf_pkg::TIME_W-1:0]  start_time,
    output logic [sjf_pkg::TIME_W-1:0]  finish_time,
    output logic                        last_result,
    output sjf_pkg::back_stat_t         stat
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_PICK
    } state_t;

    state_t state_reg;

    // job table
    logic [sjf_pkg::BURST_W-1:0] burst_tbl_reg [sjf_pkg::MAX_PROCS];
    logic [sjf_pkg::ARR_W-1:0]   arr_tbl_reg   [sjf_pkg::MAX_PROCS];
    logic [sjf_pkg::MAX_PROCS-1:0] done_reg;

    logic [sjf_pkg::CNT_W-1:0]  n_reg;
    logic [sjf_pkg::CNT_W-1:0]  scan_cnt_reg;
    logic [sjf_pkg::CNT_W-1:0]  emit_cnt_reg;
    logic [sjf_pkg::TIME_W-1:0] elapsed_reg;

    // best arrived job at the current time
    logic                        any_found_reg;
    logic [sjf_pkg::BURST_W-1:0] best_burst_reg;
    logic [sjf_pkg::ARR_W-1:0]   best_arr_reg;
    logic [sjf_pkg::IDX_W-1:0]   best_id_reg;
    // best job among the earliest pending arrivals
    logic                        early_found_reg;
    logic [sjf_pkg::BURST_W-1:0] early_burst_reg;
    logic [sjf_pkg::ARR_W-1:0]   early_arr_reg;
    logic [sjf_pkg::IDX_W-1:0]   early_id_reg;

    // result register
    logic                        out_valid_reg;
    logic [sjf_pkg::IDX_W-1:0]   out_id_reg;
    logic [sjf_pkg::BURST_W-1:0] out_burst_reg;
    logic [sjf_pkg::ARR_W-1:0]   out_arr_reg;
    logic [sjf_pkg::TIME_W-1:0]  out_start_reg;
    logic [sjf_pkg::TIME_W-1:0]  out_finish_reg;
    logic                        out_last_reg;

    logic [sjf_pkg::IDX_W-1:0]   cur_idx;
    logic [sjf_pkg::BURST_W-1:0] cur_burst;
    logic [sjf_pkg::ARR_W-1:0]   cur_arr;
    logic                        cur_pend;
    logic                        cur_arrived;
    logic                        take_best;
    logic                        take_early;
    logic                        scan_step;
    logic                        scan_last;
    logic [sjf_pkg::BURST_W-1:0] pick_burst;
    logic [sjf_pkg::ARR_W-1:0]   pick_arr;
    logic [sjf_pkg::IDX_W-1:0]   pick_id;
    logic [sjf_pkg::TIME_W-1:0]  pick_start;
    logic [sjf_pkg::TIME_W-1:0]  pick_finish;
    logic                        pick_fire;
    logic                        pick_last;
    logic                        out_free;

    assign cur_idx     = scan_cnt_reg[sjf_pkg::IDX_W-1:0];
    assign cur_burst   = burst_tbl_reg[cur_idx];
    assign cur_arr     = arr_tbl_reg[cur_idx];
    assign cur_pend    = !done_reg[cur_idx];
    assign cur_arrived = cur_pend && (sjf_pkg::TIME_W'(cur_arr) <= elapsed_reg);

    // ties on burst go to the later id
    assign take_best  = cur_arrived && (!any_found_reg || cur_burst <= best_burst_reg);
    // earliest arrival first, then smallest burst, then later id
    assign take_early = cur_pend &&
                        (!early_found_reg || cur_arr < early_arr_reg ||
                         (cur_arr == early_arr_reg && cur_burst <= early_burst_reg));

    assign scan_step = (state_reg == ST_SCAN);
    assign scan_last = (scan_cnt_reg + sjf_pkg::CNT_W'(1)) == n_reg;

    // nothing arrived: time jumps to the earliest pending arrival
    assign pick_burst  = any_found_reg ? best_burst_reg : early_burst_reg;
    assign pick_arr    = any_found_reg ? best_arr_reg   : early_arr_reg;
    assign pick_id     = any_found_reg ? best_id_reg    : early_id_reg;
    assign pick_start  = any_found_reg ? elapsed_reg : sjf_pkg::TIME_W'(early_arr_reg);
    assign pick_finish = pick_start + sjf_pkg::TIME_W'(pick_burst);

    assign out_free  = !out_valid_reg || pop;
    assign pick_fire = (state_reg == ST_PICK) && out_free;
    assign pick_last = (emit_cnt_reg + sjf_pkg::CNT_W'(1)) == n_reg;
    assign q_pop     = (state_reg == ST_LOAD) && !q_empty;

    assign empty       = !out_valid_reg;
    assign job_id      = sjf_pkg::ID_W'(out_id_reg);
    assign job_burst   = out_burst_reg;
    assign job_arrival = out_arr_reg;
    assign start_time  = out_start_reg;
    assign finish_time = out_finish_reg;
    assign last_result = out_last_reg;

    assign stat.loading = (state_reg == ST_LOAD);
    assign stat.picking = (state_reg == ST_PICK);

    // payload: table, scan candidates, result
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            burst_tbl_reg[q_word.idx] <= q_word.burst;
            arr_tbl_reg[q_word.idx]   <= q_word.arrival;
        end
        if (scan_step && take_best)
        begin
            best_burst_reg <= cur_burst;
            best_arr_reg   <= cur_arr;
            best_id_reg    <= cur_idx;
        end
        if (scan_step && take_early)
        begin
            early_burst_reg <= cur_burst;
            early_arr_reg   <= cur_arr;
            early_id_reg    <= cur_idx;
        end
        if (pick_fire)
        begin
            out_id_reg     <= pick_id;
            out_burst_reg  <= pick_burst;
            out_arr_reg    <= pick_arr;
            out_start_reg  <= pick_start;
            out_finish_reg <= pick_finish;
            out_last_reg   <= pick_last;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            done_reg        <= '0;
            n_reg           <= '0;
            scan_cnt_reg    <= '0;
            emit_cnt_reg    <= '0;
            elapsed_reg     <= '0;
            any_found_reg   <= 1'b0;
            early_found_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // a new pick refills the result register in the cycle it is popped
            if (pick_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (q_pop)
                    begin
                        done_reg[q_word.idx] <= 1'b0;
                        if (q_word.last)
                        begin
                            n_reg           <= sjf_pkg::CNT_W'(q_word.idx) +
                                               sjf_pkg::CNT_W'(1);
                            emit_cnt_reg    <= '0;
                            elapsed_reg     <= '0;
                            scan_cnt_reg    <= '0;
                            any_found_reg   <= 1'b0;
                            early_found_reg <= 1'b0;
                            state_reg       <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    any_found_reg   <= any_found_reg || take_best;
                    early_found_reg <= early_found_reg || take_early;
                    scan_cnt_reg    <= scan_cnt_reg + sjf_pkg::CNT_W'(1);
                    if (scan_last)
                    begin
                        state_reg <= ST_PICK;
                    end
                end
                ST_PICK:
                begin
                    if (pick_fire)
                    begin
                        done_reg[pick_id] <= 1'b1;
                        emit_cnt_reg      <= emit_cnt_reg + sjf_pkg::CNT_W'(1);
                        scan_cnt_reg      <= '0;
                        any_found_reg     <= 1'b0;
                        early_found_reg   <= 1'b0;
                        if (pick_last)
                        begin
                            elapsed_reg <= '0;
                            state_reg   <= ST_LOAD;
                        end
                        else
                        begin
                            elapsed_reg <= pick_finish;
                            state_reg   <= ST_SCAN;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

endmodule
